@@ hw/rtl/lsbr_pkg.sv @@
// Shared constants and types of the LSB-first bit stream reader.
`default_nettype none

package lsbr_pkg;

  localparam int BufferBytes = 2048;
  localparam int AddrW       = $clog2(BufferBytes);
  localparam int StoreBits   = BufferBytes * 8;
  localparam int HeadW       = 15;
  localparam int HeadCap     = (StoreBits < 32767) ? StoreBits : 32767;
  localparam int MaxReadBits = 64;
  localparam int CountW      = 7;
  localparam int DataW       = 64;

  localparam logic [1:0] ReqLoad   = 2'd0;
  localparam logic [1:0] ReqRead   = 2'd1;
  localparam logic [1:0] ReqRewind = 2'd2;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/lsb_first_bit_stream_reader.sv @@
// Top level of the LSB-first bit stream reader.
//
// Requests enter on start_i with req_type_i and are taken when busy_o is low.
// A load writes load_byte_i at load_addr_i; a rewind clears the bit head.
// Neither gives a result, and busy_o stays low.
// A read takes bit_count_i bits (saturated to 64) from the head, LSB first.
// The sequencer fetches the covered bytes one per cycle from the single
// byte store port and merges each into an accumulator through one shared
// byte placement shifter. A read of N bits starting at bit offset o covers
// ceil((o+N)/8) bytes, at least 1 and at most 9. After the transfer edge the
// block fetches each byte in StFetch and then passes through StDrain and
// StFinish; the result is registered in StFinish and drives result_valid_o,
// read_data_o, over_read_o and head_after_o.
// A new request is taken in the cycle the result is shown.
// Results are shown for one cycle and cannot be stalled.
// The user writes stream_length_bits on the configuration channel only while
// the block is idle; the block itself does not enforce this, and cfg_ready_o
// is always high. Bits at or past the limit read as zero and set over_read_o.
// Reset clears the head and sets the stream limit to 16384. The byte store
// is not cleared; bytes must be loaded before they are read.
`default_nettype none

module lsb_first_bit_stream_reader (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [lsbr_pkg::AddrW-1:0]        load_addr_i,
  input  wire logic [7:0]                        load_byte_i,
  input  wire logic [lsbr_pkg::CountW-1:0]       bit_count_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lsbr_pkg::HeadW-1:0]        cfg_data_i,
  output logic                                   result_valid_o,
  output logic [lsbr_pkg::DataW-1:0]             read_data_o,
  output logic                                   over_read_o,
  output logic [lsbr_pkg::HeadW-1:0]             head_after_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StFetch  = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  localparam int HeadW  = lsbr_pkg::HeadW;
  localparam int CountW = lsbr_pkg::CountW;
  localparam int DataW  = lsbr_pkg::DataW;
  localparam int AddrW  = lsbr_pkg::AddrW;
  localparam int AccW   = DataW + 8;

  logic [1:0]        state_q, state_d;
  logic [HeadW-1:0]  head_q, head_d;
  logic [HeadW-1:0]  limit_cfg_q;
  logic [AddrW-1:0]  base_q, base_d;
  logic [2:0]        off_q, off_d;
  logic [3:0]        last_q, last_d;
  logic [3:0]        idx_q, idx_d;
  logic              cap_q, cap_d;
  logic [3:0]        cap_idx_q, cap_idx_d;
  logic [CountW-1:0] nvalid_q, nvalid_d;
  logic              over_q, over_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic              res_valid_q, res_valid_d;
  logic [DataW-1:0]  res_data_q, res_data_d;
  logic              res_over_q, res_over_d;
  logic [HeadW-1:0]  res_head_q, res_head_d;

  logic              accept;
  logic [CountW-1:0] count;
  logic [HeadW-1:0]  limit;
  logic [HeadW:0]    sum;
  logic [HeadW-1:0]  room;
  logic [7:0]        offcnt;
  logic [7:0]        offcnt_m1;
  logic [7:0]        rdata;
  logic [AccW-1:0]   placed;
  logic [AccW-1:0]   aligned;
  logic [DataW-1:0]  mask;
  lsbr_pkg::mem_req_t mem_req;

  lsbr_byte_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign accept = start_i && (state_q == StIdle);

  // Read setup: count, limit, head update and byte span.
  always_comb begin
    count = (bit_count_i > CountW'(lsbr_pkg::MaxReadBits)) ?
            CountW'(lsbr_pkg::MaxReadBits) : bit_count_i;
    limit = (limit_cfg_q > HeadW'(lsbr_pkg::StoreBits)) ?
            HeadW'(lsbr_pkg::StoreBits) : limit_cfg_q;
    sum   = {1'b0, head_q} + (HeadW+1)'(count);
    room  = (limit > head_q) ? (limit - head_q) : '0;
    offcnt    = {5'b0, head_q[2:0]} + {1'b0, count};
    offcnt_m1 = offcnt - 8'd1;
  end

  // Shared placement shifter: puts the returned byte at its byte lane.
  assign placed  = {{(AccW-8){1'b0}}, rdata} << {cap_idx_q, 3'b000};
  assign aligned = acc_q >> off_q;
  assign mask    = (nvalid_q >= CountW'(DataW)) ? '1 :
                   ((DataW'(1) << nvalid_q[5:0]) - DataW'(1));

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    base_d      = base_q;
    off_d       = off_q;
    last_d      = last_q;
    idx_d       = idx_q;
    cap_d       = 1'b0;
    cap_idx_d   = cap_idx_q;
    nvalid_d    = nvalid_q;
    over_d      = over_q;
    acc_d       = cap_q ? (acc_q | placed) : acc_q;
    res_valid_d = 1'b0;
    res_data_d  = res_data_q;
    res_over_d  = res_over_q;
    res_head_d  = res_head_q;
    mem_req     = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          case (req_type_i)
            lsbr_pkg::ReqLoad: begin
              mem_req.we    = 1'b1;
              mem_req.addr  = load_addr_i;
              mem_req.wdata = load_byte_i;
            end
            lsbr_pkg::ReqRewind: begin
              head_d = '0;
            end
            lsbr_pkg::ReqRead: begin
              base_d   = head_q[AddrW+2:3];
              off_d    = head_q[2:0];
              last_d   = (offcnt == 8'd0) ? 4'd0 : offcnt_m1[6:3];
              idx_d    = 4'd0;
              nvalid_d = (room < HeadW'(count)) ? room[CountW-1:0] : count;
              over_d   = sum > {1'b0, limit};
              head_d   = (sum > (HeadW+1)'(lsbr_pkg::HeadCap)) ?
                         HeadW'(lsbr_pkg::HeadCap) : sum[HeadW-1:0];
              acc_d    = '0;
              state_d  = StFetch;
            end
            default: begin
            end
          endcase
        end
      end
      StFetch: begin
        mem_req.re   = 1'b1;
        mem_req.addr = base_q + AddrW'(idx_q);
        cap_d        = 1'b1;
        cap_idx_d    = idx_q;
        idx_d        = idx_q + 4'd1;
        if (idx_q == last_q) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        res_valid_d = 1'b1;
        res_data_d  = aligned[DataW-1:0] & mask;
        res_over_d  = over_q;
        res_head_d  = head_q;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      limit_cfg_q <= HeadW'(lsbr_pkg::StoreBits);
      cap_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cap_q       <= cap_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    off_q      <= off_d;
    last_q     <= last_d;
    idx_q      <= idx_d;
    cap_idx_q  <= cap_idx_d;
    nvalid_q   <= nvalid_d;
    over_q     <= over_d;
    acc_q      <= acc_d;
    res_data_q <= res_data_d;
    res_over_q <= res_over_d;
    res_head_q <= res_head_d;
  end

  assign busy_o         = (state_q != StIdle);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign read_data_o    = res_data_q;
  assign over_read_o    = res_over_q;
  assign head_after_o   = res_head_q;

endmodule

`default_nettype wire

@@ hw/rtl/lsbr_byte_store.sv @@
// Single-port byte store with a registered read port.
`default_nettype none

module lsbr_byte_store (
  input  wire logic              clk_i,
  input  wire lsbr_pkg::mem_req_t req_i,
  output logic [7:0]             rdata_o
);

  logic [7:0] mem [lsbr_pkg::BufferBytes];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ dv/lsbr_checker.sv @@
// Checker of the LSB-first bit stream reader: predicts each read and compares its result.
`timescale 1ns / 1ps

module lsbr_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic                        busy_i,
  input  wire logic [1:0]                  req_type_i,
  input  wire logic [lsbr_pkg::AddrW-1:0]  load_addr_i,
  input  wire logic [7:0]                  load_byte_i,
  input  wire logic [lsbr_pkg::CountW-1:0] bit_count_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_ready_i,
  input  wire logic [lsbr_pkg::HeadW-1:0]  cfg_data_i,
  input  wire logic                        result_valid_i,
  input  wire logic [lsbr_pkg::DataW-1:0]  read_data_i,
  input  wire logic                        over_read_i,
  input  wire logic [lsbr_pkg::HeadW-1:0]  head_after_i,
  output int                               pending_o,
  output int                               errors_o,
  output int                               reads_o,
  output int                               flagged_o,
  output int                               capped_o
);

  localparam int BufferBytes = lsbr_pkg::BufferBytes;
  localparam int StoreBits   = lsbr_pkg::StoreBits;
  localparam int HeadCap     = lsbr_pkg::HeadCap;
  localparam int MaxReadBits = lsbr_pkg::MaxReadBits;
  localparam int CountW      = lsbr_pkg::CountW;
  localparam int HeadW       = lsbr_pkg::HeadW;
  localparam int DataW       = lsbr_pkg::DataW;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             over;
    logic [HeadW-1:0] head;
  } read_result_t;

  logic [7:0]   byte_copy [BufferBytes];
  int           bit_head = 0;
  int           stream_len = 16384;
  read_result_t due_q [$];
  int           errors = 0;
  int           reads = 0;
  int           flagged = 0;
  int           capped = 0;

  function automatic read_result_t predict_read(logic [CountW-1:0] count_raw);
    read_result_t r;
    int           n, lim, pos, nxt, i;
    n = (int'(count_raw) > MaxReadBits) ? MaxReadBits : int'(count_raw);
    lim = (stream_len < StoreBits) ? stream_len : StoreBits;
    r = '0;
    for (i = 0; i < n; i++) begin
      pos = bit_head + i;
      if (pos < lim) begin
        r.data[i] = byte_copy[pos >> 3][pos & 7];
      end
    end
    r.over = (bit_head + n > lim);
    nxt = bit_head + n;
    if (nxt > HeadCap) begin
      nxt = HeadCap;
    end
    r.head = HeadW'(nxt);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    read_result_t want;
    if (!rst_ni) begin
      bit_head = 0;
      stream_len = 16384;
      due_q.delete();
      pending_o <= 0;
    end else begin
      // A result and a new transfer may share an edge; the result is older.
      if (result_valid_i) begin
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: result with no read outstanding: data %h over %b head %0d",
                   $time, read_data_i, over_read_i, head_after_i);
        end else begin
          want = due_q.pop_front();
          if (read_data_i !== want.data) begin
            errors++;
            $display("%0t: read_data expected %h, actual %h", $time, want.data, read_data_i);
          end
          if (over_read_i !== want.over) begin
            errors++;
            $display("%0t: over_read expected %b, actual %b", $time, want.over, over_read_i);
          end
          if (head_after_i !== want.head) begin
            errors++;
            $display("%0t: head_after expected %0d, actual %0d", $time, want.head,
                     head_after_i);
          end
          reads++;
          if (want.over) flagged++;
          if (int'(want.head) == HeadCap) capped++;
        end
      end
      if (start_i && !busy_i) begin
        case (req_type_i)
          lsbr_pkg::ReqLoad: byte_copy[load_addr_i] = load_byte_i;
          lsbr_pkg::ReqRead: begin
            want = predict_read(bit_count_i);
            bit_head = int'(want.head);
            due_q.push_back(want);
          end
          lsbr_pkg::ReqRewind: bit_head = 0;
          default: ;
        endcase
      end
      if (cfg_valid_i && cfg_ready_i) begin
        stream_len = int'(cfg_data_i);
      end
      pending_o <= due_q.size();
    end
    errors_o  <= errors;
    reads_o   <= reads;
    flagged_o <= flagged;
    capped_o  <= capped;
  end

endmodule

@@ dv/testbench.sv @@
// Stimulus and verdict for the LSB-first bit stream reader.
`timescale 1ns / 1ps

module testbench;

  localparam int AddrW       = lsbr_pkg::AddrW;
  localparam int CountW      = lsbr_pkg::CountW;
  localparam int HeadW       = lsbr_pkg::HeadW;
  localparam int DataW       = lsbr_pkg::DataW;
  localparam int BufferBytes = lsbr_pkg::BufferBytes;
  localparam int StoreBits   = lsbr_pkg::StoreBits;
  localparam int HeadCap     = lsbr_pkg::HeadCap;
  localparam int MaxReadBits = lsbr_pkg::MaxReadBits;

  localparam logic [1:0] ReqIgnored = 2'd3;
  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 16;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        req_type_i;
  logic [AddrW-1:0]  load_addr_i;
  logic [7:0]        load_byte_i;
  logic [CountW-1:0] bit_count_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [HeadW-1:0]  cfg_data_i;
  logic              result_valid_o;
  logic [DataW-1:0]  read_data_o;
  logic              over_read_o;
  logic [HeadW-1:0]  head_after_o;

  int pending, errors, reads, flagged, capped;

  // Stimulus-side view of the stream, used to keep reads on loaded bytes and to steer loads.
  bit          written [BufferBytes];
  int          head_pos = 0;
  int          limit_now = 16384;
  int unsigned idle_pct = 0;
  int unsigned stim_count = 0;
  int unsigned cycles = 0;
  int          loads = 0, rewinds = 0, ignored = 0, settings = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  lsb_first_bit_stream_reader dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .load_addr_i    (load_addr_i),
    .load_byte_i    (load_byte_i),
    .bit_count_i    (bit_count_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .read_data_o    (read_data_o),
    .over_read_o    (over_read_o),
    .head_after_o   (head_after_o)
  );

  lsbr_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_type_i     (req_type_i),
    .load_addr_i    (load_addr_i),
    .load_byte_i    (load_byte_i),
    .bit_count_i    (bit_count_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_i (result_valid_o),
    .read_data_i    (read_data_o),
    .over_read_i    (over_read_o),
    .head_after_i   (head_after_o),
    .pending_o      (pending),
    .errors_o       (errors),
    .reads_o        (reads),
    .flagged_o      (flagged),
    .capped_o       (capped)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_req(logic [1:0] kind, logic [AddrW-1:0] addr, logic [7:0] value,
                          logic [CountW-1:0] count);
    int n;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    req_type_i  <= kind;
    load_addr_i <= addr;
    load_byte_i <= value;
    bit_count_i <= count;
    do @(posedge clk_i); while (busy_o);
    case (kind)
      lsbr_pkg::ReqLoad: begin
        written[addr] = 1'b1;
        loads++;
      end
      lsbr_pkg::ReqRead: begin
        n = (int'(count) > MaxReadBits) ? MaxReadBits : int'(count);
        head_pos = (head_pos + n > HeadCap) ? HeadCap : head_pos + n;
      end
      lsbr_pkg::ReqRewind: begin
        head_pos = 0;
        rewinds++;
      end
      default: ignored++;
    endcase
  endtask

  task automatic read_bits(logic [CountW-1:0] count);
    int n, idx, lim;
    n = (int'(count) > MaxReadBits) ? MaxReadBits : int'(count);
    lim = (limit_now < StoreBits) ? limit_now : StoreBits;
    // Every byte that holds a bit below the stream limit and that the read
    // could touch is loaded first; bytes past the limit are fetched but masked.
    for (idx = head_pos >> 3; (idx <= (head_pos + n) >> 3) && (idx * 8 < lim); idx++) begin
      if (!written[idx]) begin
        send_req(lsbr_pkg::ReqLoad, AddrW'(idx), 8'($urandom_range(255)),
                 CountW'($urandom));
      end
    end
    send_req(lsbr_pkg::ReqRead, AddrW'($urandom), 8'($urandom), count);
  endtask

  // Holds the sender off until every outstanding read has returned.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [HeadW-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_now = int'(value);
    settings++;
  endtask

  task automatic random_item(bit long_run);
    int unsigned       pick;
    logic [CountW-1:0] count;
    logic [AddrW-1:0]  addr;
    idle_pct = (stim_count < 200) ? 31 : (stim_count < 400) ? 75 : 0;
    stim_count++;
    pick = $urandom_range(99);
    if (long_run) begin
      count = CountW'($urandom_range(127, 32));
    end else begin
      case ($urandom_range(9))
        0: count = '0;
        1: count = CountW'(MaxReadBits);
        2: count = CountW'($urandom_range(127, MaxReadBits + 1));
        default: count = CountW'($urandom_range(MaxReadBits, 1));
      endcase
    end
    if (pick < (long_run ? 85 : 55)) begin
      read_bits(count);
    end else if (!long_run && pick < 67) begin
      send_req(lsbr_pkg::ReqRewind, AddrW'($urandom), 8'($urandom), CountW'($urandom));
    end else if (pick < 96) begin
      // Overwriting bytes just ahead of the head makes fresh values get read.
      if ($urandom_range(1)) begin
        addr = AddrW'(((head_pos >> 3) + int'($urandom_range(12))) % BufferBytes);
      end else begin
        addr = AddrW'($urandom);
      end
      send_req(lsbr_pkg::ReqLoad, addr, 8'($urandom), CountW'($urandom));
    end else begin
      send_req(ReqIgnored, AddrW'($urandom), 8'($urandom), CountW'($urandom));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_type_i  = lsbr_pkg::ReqLoad;
    load_addr_i = '0;
    load_byte_i = '0;
    bit_count_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_limit(15'd16384);
    send_req(lsbr_pkg::ReqLoad, AddrW'(0), 8'hA5, '0);
    send_req(lsbr_pkg::ReqLoad, AddrW'(1), 8'hFF, 7'h7F);
    send_req(lsbr_pkg::ReqLoad, AddrW'(2), 8'h00, '0);
    send_req(lsbr_pkg::ReqLoad, AddrW'(BufferBytes - 1), 8'h5A, '0);
    read_bits(7'd1);
    read_bits(7'd0);
    read_bits(7'd7);
    read_bits(CountW'(MaxReadBits));
    read_bits(7'h7F);
    send_req(ReqIgnored, '1, '1, '1);
    send_req(lsbr_pkg::ReqRewind, '0, '0, '0);
    read_bits(CountW'(MaxReadBits));
    // With a zero limit every bit reads as zero and every read is flagged.
    write_limit(15'd0);
    read_bits(7'd0);
    read_bits(7'd5);
    write_limit(15'd12);
    send_req(lsbr_pkg::ReqRewind, '1, '1, '1);
    read_bits(7'd10);
    read_bits(7'd10);
    read_bits(7'd0);

    write_limit(15'd16384);
    repeat (40) random_item(1'b0);
    write_limit(15'd0);
    repeat (25) random_item(1'b0);
    write_limit(15'd1);
    repeat (25) random_item(1'b0);
    write_limit(15'd100);
    repeat (40) random_item(1'b0);
    // Run the head up to saturation under a short limit, then check that a
    // limit above the store size is capped to it.
    send_req(lsbr_pkg::ReqRewind, AddrW'($urandom), 8'($urandom), CountW'($urandom));
    while (head_pos < HeadCap) random_item(1'b1);
    write_limit(15'h7FFF);
    repeat (20) random_item(1'b1);
    write_limit(HeadW'($urandom_range(16383)));
    repeat (40) random_item(1'b0);
    write_limit(15'd16383);
    repeat (25) random_item(1'b0);
    drain();

    $display("Checked %0d reads, %0d flagged past the stream limit, %0d at the head cap,",
             reads, flagged, capped);
    $display("with %0d loads, %0d rewinds and %0d ignored requests over %0d limit settings.",
             loads, rewinds, ignored, settings);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/lsbr_pkg.sv
hw/rtl/lsbr_byte_store.sv
hw/rtl/lsb_first_bit_stream_reader.sv
dv/lsbr_checker.sv
dv/testbench.sv
